// ===== rtl/ist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_pkg: shared types and codes for the integer set table
// Request and response payloads, table entry layout, action and status codes,
// and the interface between the sequencer and the remainder unit.
// ----------------------------------------------------------------------------
package ist_pkg;

   // Action codes carried in a request
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;
   localparam logic [1:0] ACT_RMMULT = 2'd3;

   // Status codes returned in a response
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_FULL     = 2'd1;
   localparam logic [1:0] STS_ZERO_DIV = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] value;
   } ist_req_type;

   typedef struct packed {
      logic       was_present;
      logic [6:0] member_count;
      logic [1:0] status;
   } ist_rsp_type;

   // One table entry: valid mark and stored value
   typedef struct packed {
      logic        valid;
      logic [31:0] value;
   } ist_slot_type;

   // Sequencer to remainder unit
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } ist_div_req_type;

   // Remainder unit to sequencer
   typedef struct packed {
      logic done;
      logic rem_zero;
   } ist_div_rsp_type;

   // Two's complement magnitude; the most negative value maps to 2^31
   function automatic logic [31:0] magnitude(input logic [31:0] x);
      magnitude = x[31] ? (32'd0 - x) : x;
   endfunction

endpackage

// ===== rtl/ist_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_slot_mem: slot storage
// One write port and one read port, read data registered.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module ist_slot_mem #(
   parameter int DEPTH = 64,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  ist_pkg::ist_slot_type wr_data,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_addr,
   output ist_pkg::ist_slot_type rd_data
);

   ist_pkg::ist_slot_type mem [DEPTH];
   ist_pkg::ist_slot_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ist_rem_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_rem_unit: serial remainder test
// Restoring division, one quotient bit per cycle, 32 steps. Reports whether
// the dividend is an exact multiple of the (nonzero) divisor.
// ----------------------------------------------------------------------------
module ist_rem_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  ist_pkg::ist_div_req_type div_req,
   output ist_pkg::ist_div_rsp_type div_rsp
);

   logic        busy_ff,  busy_in;
   logic        done_ff,  done_in;
   logic [4:0]  step_ff,  step_in;
   logic [31:0] rem_ff,   rem_in;
   logic [31:0] dvd_ff,   dvd_in;
   logic [31:0] dsr_ff,   dsr_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   // One restoring step while busy; load the operands on start
   always_comb begin
      shifted = {rem_ff, dvd_ff[31]};
      diff    = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (busy_ff) begin
         rem_in  = diff[32] ? shifted[31:0] : diff[31:0];
         dvd_in  = {dvd_ff[30:0], 1'b0};
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         step_in = 5'd0;
         rem_in  = 32'd0;
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.rem_zero = (rem_ff == 32'd0);

endmodule

// ===== rtl/integer_set_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_set_table: set of distinct signed 32-bit integers
// Each request scans every slot, then applies its update and loads the response
// register; in remove-multiples with a nonzero value, each other valid member is
// tested by the serial remainder unit during the scan. Requests are taken one at a
// time; the scan reads one slot per cycle from the slot memory read port while no
// remainder test runs. Reset: count and control clear at once, then a clearing
// pass marks every slot free; no request is accepted during that pass.
// ----------------------------------------------------------------------------
module integer_set_table #(
   parameter int SLOTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ist_pkg::ist_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ist_pkg::ist_rsp_type rsp_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

   state_type            state_ff,    state_in;
   logic [IDX_W-1:0]     chk_idx_ff,  chk_idx_in;
   logic [1:0]           act_ff,      act_in;
   logic [31:0]          val_ff,      val_in;
   logic                 hit_ff,      hit_in;
   logic [IDX_W-1:0]     hit_idx_ff,  hit_idx_in;
   logic                 free_ff,     free_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]     count_ff,    count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ist_pkg::ist_rsp_type rsp_data_ff, rsp_data_in;

   logic                     mem_wr_en;
   logic [IDX_W-1:0]         mem_wr_addr;
   ist_pkg::ist_slot_type    mem_wr_data;
   logic                     mem_rd_en;
   logic [IDX_W-1:0]         mem_rd_addr;
   ist_pkg::ist_slot_type    mem_rd_data;
   ist_pkg::ist_div_req_type div_req;
   ist_pkg::ist_div_rsp_type div_rsp;

   logic [31:0] divisor;
   logic        slot_match;
   logic        need_div;
   logic        advance;
   logic [1:0]  fin_status;

   ist_slot_mem #(
      .DEPTH (SLOTS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ist_rem_unit u_rem (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign divisor    = ist_pkg::magnitude(val_ff);
   assign slot_match = mem_rd_data.valid && (mem_rd_data.value == val_ff);
   assign need_div   = (act_ff == ist_pkg::ACT_RMMULT) && (divisor != 32'd0) &&
                       mem_rd_data.valid && !slot_match;

   // Sequencer: scan, remainder tests, final update and response
   always_comb begin
      state_in     = state_ff;
      chk_idx_in   = chk_idx_ff;
      act_in       = act_ff;
      val_in       = val_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = chk_idx_ff;
      mem_wr_data  = '{valid: 1'b0, value: mem_rd_data.value};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = chk_idx_ff + IDX_W'(1);
      div_req      = '{start: 1'b0, dividend: ist_pkg::magnitude(mem_rd_data.value),
                       divisor: divisor};
      advance      = 1'b0;
      fin_status   = ist_pkg::STS_OK;

      unique case (state_ff)
         // Mark every slot free after reset
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = '{valid: 1'b0, value: 32'd0};
            chk_idx_in  = chk_idx_ff + IDX_W'(1);
            if (chk_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end

         // Take a request and read slot zero
         ST_IDLE: begin
            if (req_valid) begin
               act_in      = req_data.action;
               val_in      = req_data.value;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               chk_idx_in  = '0;
               mem_rd_en   = 1'b1;
               mem_rd_addr = '0;
               state_in    = ST_SCAN;
            end
         end

         // Check the slot just read
         ST_SCAN: begin
            if (slot_match && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = chk_idx_ff;
            end
            if (!mem_rd_data.valid && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = chk_idx_ff;
            end
            if (need_div) begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               advance = 1'b1;
            end
         end

         // Wait for the remainder; drop the member if it divides evenly
         ST_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.rem_zero) begin
                  mem_wr_en = 1'b1;
                  count_in  = count_ff - CNT_W'(1);
               end
               advance = 1'b1;
            end
         end

         // Apply insert or delete and load the response register
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               priority if (act_ff == ist_pkg::ACT_INSERT && !hit_ff) begin
                  if (free_ff) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = free_idx_ff;
                     mem_wr_data = '{valid: 1'b1, value: val_ff};
                     count_in    = count_ff + CNT_W'(1);
                  end else begin
                     fin_status = ist_pkg::STS_FULL;
                  end
               end else if (act_ff == ist_pkg::ACT_DELETE && hit_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = hit_idx_ff;
                  mem_wr_data = '{valid: 1'b0, value: val_ff};
                  count_in    = count_ff - CNT_W'(1);
               end else if (act_ff == ist_pkg::ACT_RMMULT && divisor == 32'd0) begin
                  fin_status = ist_pkg::STS_ZERO_DIV;
               end else begin
                  fin_status = ist_pkg::STS_OK;
               end
               rsp_data_in.was_present  = hit_ff;
               rsp_data_in.member_count = 7'(count_in);
               rsp_data_in.status       = fin_status;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      // Step to the next slot or finish the scan
      if (advance) begin
         if (chk_idx_ff == LAST_IDX) begin
            state_in = ST_FIN;
         end else begin
            mem_rd_en  = 1'b1;
            chk_idx_in = chk_idx_ff + IDX_W'(1);
            state_in   = ST_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         chk_idx_ff   <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_idx_ff   <= chk_idx_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request payload and scan results
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      val_ff      <= val_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
